// File: rtl/spptd_pkg.sv
// Shared types and constants for the stereo ping-pong tape delay.
// Holds the controller/datapath command and status structs, register indexes
// and fixed-point gains. Depends on nothing.
`timescale 1ns / 1ps

package spptd_pkg;

    // Parameter defaults
    localparam int DEF_DELAY_DEPTH      = 131072;
    localparam int DEF_SAMPLE_BITS      = 16;
    localparam int DEF_TANH_TABLE_DEPTH = 1024;

    // Configuration register indexes
    localparam logic [2:0] CFG_DELAY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_MIX_LEVEL    = 3'd1;
    localparam logic [2:0] CFG_FEEDBACK     = 3'd2;
    localparam logic [2:0] CFG_TAPE_MODE    = 3'd3;
    localparam logic [2:0] CFG_MONO_INPUT   = 3'd4;
    localparam logic [2:0] CFG_CENTRE_MODE  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register reset values
    localparam logic [16:0] RST_DELAY_LENGTH = 17'd24000;
    localparam logic [16:0] RST_MIX_LEVEL    = 17'd32768;
    localparam logic [15:0] RST_FEEDBACK     = 16'd32768;

    // Fixed-point gains (Q0.16 / Q1.16)
    localparam logic [16:0] LP_KEEP      = 17'd52429;
    localparam logic [16:0] LP_TAKE      = 17'd13107;
    localparam logic [16:0] CROSS_GAIN   = 17'd46334;
    localparam logic [16:0] UNITY_Q16    = 17'd65536;
    localparam logic [16:0] MIX_MAX      = 17'd65536;
    localparam logic [15:0] FEEDBACK_MAX = 16'd64881;

    // Multiplier operand pair
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_LPL_KEEP,
        MUL_DL_TAKE,
        MUL_LPR_KEEP,
        MUL_DR_TAKE,
        MUL_FBK_L,
        MUL_FBK_R,
        MUL_DRY_L,
        MUL_WET_L,
        MUL_DRY_R,
        MUL_WET_R
    } t_mul;

    // Accumulator action on the registered product
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_LOAD_SUM2,
        ACC_LOAD_SH16
    } t_acc;

    // Destination of the rounded, saturated accumulator
    typedef enum logic [2:0] {
        DST_NONE,
        DST_LPL,
        DST_LPR,
        DST_FL,
        DST_FR,
        DST_OL,
        DST_OR
    } t_dst;

    // Saturation lookup source (LPL/LPR results go to the delay taps, FL/FR back to the feedback sample)
    typedef enum logic [2:0] {
        TS_NONE,
        TS_LPL,
        TS_LPR,
        TS_FL,
        TS_FR
    } t_ts;

    typedef struct packed {
        logic load;
        logic tap;
        logic mem_wr;
        logic present;
        t_mul mul;
        t_acc acc;
        t_dst dst;
        t_ts  ts;
    } t_cmd;

    typedef struct packed {
        logic tape;
    } t_stat;

endpackage

// File: rtl/spptd_tanh_rom.sv
// Saturation ROM: tanh(1.5x) table with registered read, sign applied after.
// Table is built at elaboration. Depends on spptd_pkg.
`timescale 1ns / 1ps

module spptd_tanh_rom
    import spptd_pkg::*;
#(
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    output logic signed [SAMPLE_BITS-1:0] o_y
);

    localparam int S    = SAMPLE_BITS;
    localparam int D    = TANH_TABLE_DEPTH;
    localparam int FRAC = S - 1;
    localparam int IW   = $clog2(D);
    localparam int PW   = S + 1 + IW + 1;

    typedef logic [S-1:0] t_rom [D];

    // Restoring division, used only while the table is built
    function automatic longint unsigned cdiv(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Integer exponential series in Q28
    function automatic t_rom build_rom();
        t_rom              rom;
        longint unsigned   one;
        longint unsigned   z;
        longint unsigned   e;
        longint unsigned   term;
        longint unsigned   num;
        longint unsigned   den;
        one = 64'd1 << 28;
        for (int k = 0; k < D; k++) begin
            z    = ((64'd3 * 64'(k)) << 28) / 64'(D);
            e    = one;
            term = one;
            for (int n = 1; n <= 40; n++) begin
                term = ((term * z) >> 28) / 64'(n);
                e    = e + term;
            end
            num    = (e - one) << FRAC;
            den    = e + one;
            rom[k] = S'(cdiv(num + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [S:0]    mag;
    logic [PW-1:0] idx_full;
    logic [IW-1:0] idx;
    logic [S-1:0]  r_q;
    logic          r_neg;

    // Index = floor(|x| * D / 2^FRAC), limited to D-1
    always_comb begin
        mag      = i_x[S-1] ? ((S+1)'(0) - {i_x[S-1], i_x}) : {1'b0, i_x};
        idx_full = (PW'(mag) * PW'(D)) >> FRAC;
        if (idx_full >= PW'(D)) begin
            idx = IW'(D - 1);
        end else begin
            idx = idx_full[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= ROM[idx];
        r_neg <= i_x[S-1];
    end

    assign o_y = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// File: rtl/spptd_ctrl.sv
// Sequencer for the delay: steps the shared multiplier schedule and handles
// both stream handshakes. Depends on spptd_pkg.
`timescale 1ns / 1ps

module spptd_ctrl
    import spptd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_TAP,
        S_LP0, S_LP1, S_LP2, S_LP3, S_LP4, S_LP5, S_LP6, S_LP7,
        S_FB0, S_FB1, S_FB2, S_FB3, S_FB4, S_FB5, S_FB6, S_FB7, S_FB8, S_FB9,
        S_DONE
    } t_state;

    t_state r_state;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !o_out_valid || i_out_ready;

    // Command decode per step
    always_comb begin
        o_cmd = '{load: 1'b0, tap: 1'b0, mem_wr: 1'b0, present: 1'b0,
                  mul: MUL_NONE, acc: ACC_NONE, dst: DST_NONE, ts: TS_NONE};
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_TAP:  o_cmd.tap = 1'b1;
            S_LP0:  o_cmd.mul = MUL_LPL_KEEP;
            S_LP1: begin
                o_cmd.mul = MUL_DL_TAKE;
                o_cmd.acc = ACC_LOAD;
            end
            S_LP2: begin
                o_cmd.mul = MUL_LPR_KEEP;
                o_cmd.acc = ACC_ADD;
            end
            S_LP3: begin
                o_cmd.mul = MUL_DR_TAKE;
                o_cmd.acc = ACC_LOAD;
                o_cmd.dst = DST_LPL;
            end
            S_LP4: begin
                o_cmd.acc = ACC_ADD;
                o_cmd.ts  = TS_LPL;
            end
            S_LP5: o_cmd.dst = DST_LPR;
            S_LP6: o_cmd.ts = TS_LPR;
            S_LP7: ;
            S_FB0: o_cmd.mul = MUL_FBK_L;
            S_FB1: begin
                o_cmd.mul = MUL_FBK_R;
                o_cmd.acc = ACC_LOAD_SUM2;
            end
            S_FB2: begin
                o_cmd.acc = ACC_LOAD_SUM2;
                o_cmd.dst = DST_FL;
            end
            S_FB3: begin
                o_cmd.dst = DST_FR;
                o_cmd.ts  = i_stat.tape ? TS_FL : TS_NONE;
            end
            S_FB4: begin
                o_cmd.mul = MUL_DRY_L;
                o_cmd.ts  = i_stat.tape ? TS_FR : TS_NONE;
            end
            S_FB5: begin
                o_cmd.mul = MUL_WET_L;
                o_cmd.acc = ACC_LOAD_SH16;
            end
            S_FB6: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.mul    = MUL_DRY_R;
                o_cmd.acc    = ACC_ADD;
            end
            S_FB7: begin
                o_cmd.mul = MUL_WET_R;
                o_cmd.acc = ACC_LOAD_SH16;
                o_cmd.dst = DST_OL;
            end
            S_FB8:  o_cmd.acc = ACC_ADD;
            S_FB9:  o_cmd.dst = DST_OR;
            S_DONE: o_cmd.present = out_free;
            default: ;
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // a new result may load in the cycle the old one is taken
            if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_TAP;
                S_TAP:   r_state <= i_stat.tape ? S_LP0 : S_FB0;
                S_LP0:   r_state <= S_LP1;
                S_LP1:   r_state <= S_LP2;
                S_LP2:   r_state <= S_LP3;
                S_LP3:   r_state <= S_LP4;
                S_LP4:   r_state <= S_LP5;
                S_LP5:   r_state <= S_LP6;
                S_LP6:   r_state <= S_LP7;
                S_LP7:   r_state <= S_FB0;
                S_FB0:   r_state <= S_FB1;
                S_FB1:   r_state <= S_FB2;
                S_FB2:   r_state <= S_FB3;
                S_FB3:   r_state <= S_FB4;
                S_FB4:   r_state <= S_FB5;
                S_FB5:   r_state <= S_FB6;
                S_FB6:   r_state <= S_FB7;
                S_FB7:   r_state <= S_FB8;
                S_FB8:   r_state <= S_FB9;
                S_FB9:   r_state <= S_DONE;
                S_DONE:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/spptd_dpath.sv
// Datapath: configuration registers, delay memories, shared multiplier,
// accumulator with round/saturate, low-pass states and output registers.
// Depends on spptd_pkg and spptd_tanh_rom.
`timescale 1ns / 1ps

module spptd_dpath
    import spptd_pkg::*;
#(
    parameter int DELAY_DEPTH      = DEF_DELAY_DEPTH,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_in_left,
    input  logic signed [SAMPLE_BITS-1:0] i_in_right,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat
);

    localparam int S     = SAMPLE_BITS;
    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int LW    = (AW > 17) ? AW : 17;
    localparam int AOP_W = S + 2;
    localparam int BOP_W = 34;
    localparam int PR_W  = AOP_W + BOP_W;
    localparam int ACC_W = S + 34;

    localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
    localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(1) << 15;
    localparam logic signed [ACC_W-1:0] RND32 = ACC_W'(1) << 31;

    // Configuration registers
    logic [16:0] r_delay_length;
    logic [16:0] r_mix;
    logic [15:0] r_fbk;
    logic        r_tape;
    logic        r_mono_in;
    logic        r_centre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length <= RST_DELAY_LENGTH;
            r_mix          <= RST_MIX_LEVEL;
            r_fbk          <= RST_FEEDBACK;
            r_tape         <= 1'b0;
            r_mono_in      <= 1'b0;
            r_centre       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY_LENGTH: r_delay_length <= i_cfg_data[16:0];
                CFG_MIX_LEVEL:    r_mix          <= i_cfg_data[16:0];
                CFG_FEEDBACK:     r_fbk          <= i_cfg_data[15:0];
                CFG_TAPE_MODE:    r_tape         <= i_cfg_data[0];
                CFG_MONO_INPUT:   r_mono_in      <= i_cfg_data[0];
                CFG_CENTRE_MODE:  r_centre       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic mono_path;
    assign mono_path   = r_mono_in || r_centre;
    assign o_stat.tape = r_tape;

    // Item state
    logic [AW-1:0]         r_wp;
    logic                  r_wrapped;
    logic signed [S-1:0]   r_lpl;
    logic signed [S-1:0]   r_lpr;
    logic signed [S-1:0]   r_xl;
    logic signed [S-1:0]   r_xr;
    logic signed [S-1:0]   r_dl;
    logic signed [S-1:0]   r_dr;
    logic signed [S-1:0]   r_fl;
    logic signed [S-1:0]   r_fr;
    logic signed [S-1:0]   r_ol;
    logic signed [S-1:0]   r_or;
    logic [32:0]           r_mixg;
    logic [16:0]           r_dry;
    logic [15:0]           r_fbkg;
    logic                  r_rd_ok;
    logic [S-1:0]          r_q_l;
    logic [S-1:0]          r_q_r;
    logic signed [PR_W-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_ts                   r_ts_dst;

    // Clamped controls
    logic [LW-1:0] len_ext;
    logic [AW-1:0] tap_dist;
    logic [16:0]   mix_c;
    logic [15:0]   fbk_c;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd;

    always_comb begin
        len_ext = LW'(r_delay_length);
        if (len_ext == '0) begin
            tap_dist = AW'(1);
        end else if (len_ext > LW'(DELAY_DEPTH - 1)) begin
            tap_dist = AW'(DELAY_DEPTH - 1);
        end else begin
            tap_dist = len_ext[AW-1:0];
        end
        mix_c  = (r_mix > MIX_MAX) ? MIX_MAX : r_mix;
        fbk_c  = (r_fbk > FEEDBACK_MAX) ? FEEDBACK_MAX : r_fbk;
        rd_sum = (AW+1)'(r_wp) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(tap_dist);
        if (rd_sum >= (AW+1)'(DELAY_DEPTH)) begin
            rd_sum = rd_sum - (AW+1)'(DELAY_DEPTH);
        end
        rd = rd_sum[AW-1:0];
    end

    // Delay memories: one write and one read per item
    logic [S-1:0] r_mem_l [DELAY_DEPTH];
    logic [S-1:0] r_mem_r [DELAY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem_l[r_wp] <= r_fl;
            r_mem_r[r_wp] <= r_fr;
        end
        if (i_cmd.load) begin
            r_q_l <= r_mem_l[rd];
            r_q_r <= r_mem_r[rd];
        end
    end

    // Multiplier operand select
    logic signed [AOP_W-1:0] mul_a;
    logic signed [BOP_W-1:0] mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul)
            MUL_LPL_KEEP: begin
                mul_a = AOP_W'(r_lpl);
                mul_b = BOP_W'(LP_KEEP);
            end
            MUL_DL_TAKE: begin
                mul_a = AOP_W'(r_dl);
                mul_b = BOP_W'(LP_TAKE);
            end
            MUL_LPR_KEEP: begin
                mul_a = AOP_W'(r_lpr);
                mul_b = BOP_W'(LP_KEEP);
            end
            MUL_DR_TAKE: begin
                mul_a = AOP_W'(r_dr);
                mul_b = BOP_W'(LP_TAKE);
            end
            MUL_FBK_L: begin
                mul_a = mono_path ? AOP_W'(r_dl) : AOP_W'(r_dr);
                mul_b = BOP_W'(r_fbkg);
            end
            MUL_FBK_R: begin
                mul_a = AOP_W'(r_dl);
                mul_b = BOP_W'(r_fbkg);
            end
            MUL_DRY_L: begin
                mul_a = AOP_W'(r_xl);
                mul_b = BOP_W'(r_dry);
            end
            MUL_WET_L: begin
                // ping-pong: left hears the inverted right tap
                mul_a = mono_path ? AOP_W'(r_dl) : -AOP_W'(r_dr);
                mul_b = BOP_W'(r_mixg);
            end
            MUL_DRY_R: begin
                mul_a = AOP_W'(r_xr);
                mul_b = BOP_W'(r_dry);
            end
            MUL_WET_R: begin
                mul_a = AOP_W'(r_dl);
                mul_b = BOP_W'(r_mixg);
            end
            default: ;
        endcase
    end

    // Round half up and saturate
    function automatic logic signed [S-1:0] rnd_sat(input logic signed [ACC_W-1:0] v,
                                                     input logic wide);
        logic signed [ACC_W-1:0] t;
        t = wide ? ((v + RND32) >>> 32) : ((v + RND16) >>> 16);
        if (t > SMAX) begin
            return SMAX[S-1:0];
        end else if (t < SMIN) begin
            return SMIN[S-1:0];
        end
        return t[S-1:0];
    endfunction

    logic signed [S-1:0]     res16;
    logic signed [S-1:0]     res32;
    logic signed [S:0]       in_sum;
    logic signed [ACC_W-1:0] sum2;

    assign res16  = rnd_sat(r_acc, 1'b0);
    assign res32  = rnd_sat(r_acc, 1'b1);
    assign in_sum = (S+1)'(r_xl) + (S+1)'(r_xr);
    assign sum2   = ACC_W'(in_sum) <<< 15;

    // Saturation lookup
    logic signed [S-1:0] ts_x;
    logic signed [S-1:0] ts_y;

    always_comb begin
        case (i_cmd.ts)
            TS_LPL:  ts_x = r_lpl;
            TS_LPR:  ts_x = r_lpr;
            TS_FL:   ts_x = r_fl;
            TS_FR:   ts_x = r_fr;
            default: ts_x = '0;
        endcase
    end

    spptd_tanh_rom #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_tanh (
        .i_clk (i_clk),
        .i_x   (ts_x),
        .o_y   (ts_y)
    );

    // Control state: pointer, fill mark, low-pass, lookup pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_lpl     <= '0;
            r_lpr     <= '0;
            r_ts_dst  <= TS_NONE;
        end else begin
            r_ts_dst <= i_cmd.ts;
            if (i_cmd.mem_wr) begin
                if (r_wp == AW'(DELAY_DEPTH - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + AW'(1);
                end
            end
            if (i_cmd.dst == DST_LPL) r_lpl <= res16;
            if (i_cmd.dst == DST_LPR) r_lpr <= res16;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.acc)
            ACC_LOAD:      r_acc <= r_prod[ACC_W-1:0];
            ACC_ADD:       r_acc <= r_acc + r_prod[ACC_W-1:0];
            ACC_LOAD_SUM2: r_acc <= sum2 + r_prod[ACC_W-1:0];
            ACC_LOAD_SH16: r_acc <= r_prod[ACC_W-1:0] <<< 16;
            default: ;
        endcase
        if (i_cmd.load) begin
            r_xl    <= i_in_left;
            r_xr    <= r_mono_in ? i_in_left : i_in_right;
            r_dry   <= UNITY_Q16 - mix_c;
            r_mixg  <= mono_path ? {mix_c, 16'd0} : 33'(mix_c) * 33'(CROSS_GAIN);
            r_fbkg  <= fbk_c;
            // entries not yet written since reset read as zero
            r_rd_ok <= r_wrapped || (rd < r_wp);
        end
        if (i_cmd.tap) begin
            r_dl <= r_rd_ok ? $signed(r_q_l) : '0;
            r_dr <= r_rd_ok ? $signed(r_q_r) : '0;
        end
        case (i_cmd.dst)
            DST_FL: r_fl <= res16;
            DST_FR: r_fr <= res16;
            DST_OL: r_ol <= res32;
            DST_OR: r_or <= res32;
            default: ;
        endcase
        case (r_ts_dst)
            TS_LPL: r_dl <= ts_y;
            TS_LPR: r_dr <= ts_y;
            TS_FL:  r_fl <= ts_y;
            TS_FR:  r_fr <= ts_y;
            default: ;
        endcase
        if (i_cmd.present) begin
            o_out_left  <= r_ol;
            o_out_right <= r_or;
        end
    end

endmodule

// File: rtl/stereo_ping_pong_tape_delay.sv
// Top level of the stereo ping-pong tape delay: stream ports, configuration
// port, controller and datapath. Depends on spptd_pkg, spptd_ctrl, spptd_dpath.
`timescale 1ns / 1ps

// One stereo pair goes in per transaction and one pair comes out. The time
// from acceptance to result is set by the schedule of the single shared
// multiplier and the registered saturation ROM, and is longer with tape mode
// on. A new pair is accepted once the previous one has reached the output
// register, so the block takes no new pair while it still works on one. The
// delay memories need no clearing pass: a fill mark makes taps that were
// never written since reset read as silence. Configuration writes may only
// be made while the block is idle.
module stereo_ping_pong_tape_delay
    import spptd_pkg::*;
#(
    parameter int DELAY_DEPTH      = DEF_DELAY_DEPTH,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH,
    localparam int TDATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // in_left, in_right, zero fill
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_left, out_right, zero fill
    output logic [TDATA_W-1:0]    m_axis_tdata
);

    localparam int S = SAMPLE_BITS;

    t_cmd  cmd;
    t_stat stat;

    logic signed [S-1:0] out_left;
    logic signed [S-1:0] out_right;

    spptd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spptd_dpath #(
        .DELAY_DEPTH      (DELAY_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_left   (s_axis_tdata[S-1:0]),
        .i_in_right  (s_axis_tdata[2*S-1:S]),
        .o_out_left  (out_left),
        .o_out_right (out_right),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // Pack result pair, left in the low bits
    assign m_axis_tdata = TDATA_W'({out_right, out_left});

endmodule

// File: tb/stereo_ping_pong_tape_delay_test.sv
// Self-checking testbench for the stereo ping-pong tape delay.
// Drives stereo pairs over the stream ports and checks each output pair against
// typed values or an internal fixed-point model of the delay. Depends on spptd_pkg and the RTL.
`timescale 1ns / 1ps

module stereo_ping_pong_tape_delay_test;
    import spptd_pkg::*;

    localparam int DEPTH        = 131072;
    localparam int ROM_DEPTH    = 1024;
    localparam int CYCLE_MAX    = 400000;
    localparam int SETTLE       = 30;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_LEN    = 70;
    localparam int NUM_DIRECTED = 12;

    typedef struct {
        logic signed [15:0] l;
        logic signed [15:0] r;
    } t_pair;

    typedef struct {
        logic signed [15:0] l;
        logic signed [15:0] r;
        bit                 typed;
        logic signed [15:0] el;
        logic signed [15:0] er;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;

    stereo_ping_pong_tape_delay uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Model state and register copies
    int          tanh_rom [ROM_DEPTH];
    int          echo_l [DEPTH];
    int          echo_r [DEPTH];
    int          wr_ptr;
    longint      lp_l, lp_r;
    int unsigned reg_delay, reg_mix, reg_fbk;
    bit          reg_tape, reg_mono, reg_centre;

    t_pair expected_pairs[$];
    int    errors = 0;
    int    outputs_seen = 0;
    int    cycles = 0;
    bit    idle_on = 1'b1;
    int    tape_items = 0, mono_items = 0, cross_items = 0;

    // Q28 exponential series, tanh(1.5x) table
    task automatic build_tanh;
        longint unsigned one, z, e, term, num, den;
        one = 64'd1 << 28;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            z = ((64'd3 * k) << 28) / ROM_DEPTH;
            e = one;
            term = one;
            for (int n = 1; n <= 40; n++) begin
                term = ((term * z) >> 28) / n;
                e += term;
            end
            num = (e - one) << 15;
            den = e + one;
            tanh_rom[k] = int'((num + den / 2) / den);
        end
    endtask

    function automatic longint rnd16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint soft_clip(longint x);
        longint unsigned mag, idx;
        longint v;
        mag = (x < 0) ? -x : x;
        idx = (mag * ROM_DEPTH) >> 15;
        if (idx >= ROM_DEPTH) idx = ROM_DEPTH - 1;
        v = tanh_rom[idx];
        return (x < 0) ? -v : v;
    endfunction

    // One step of the delay line; updates model state
    function automatic t_pair delay_step(logic signed [15:0] in_l, logic signed [15:0] in_r);
        int     tap_dist, rd;
        longint mix, fbk, xl, xr, dl, dr, wl, wr, gain, sum2, fl, fr;
        bit     mono_path;
        t_pair  res;
        mono_path = reg_mono || reg_centre;
        tap_dist = reg_delay;
        if (tap_dist < 1) tap_dist = 1;
        if (tap_dist > DEPTH - 1) tap_dist = DEPTH - 1;
        mix = (reg_mix > 65536) ? 65536 : reg_mix;
        fbk = (reg_fbk > 64881) ? 64881 : reg_fbk;
        rd = (wr_ptr + DEPTH - tap_dist) % DEPTH;
        dl = echo_l[rd];
        dr = echo_r[rd];
        if (reg_tape) begin
            lp_l = clip(rnd16(lp_l * 52429 + dl * 13107));
            lp_r = clip(rnd16(lp_r * 52429 + dr * 13107));
            dl = soft_clip(lp_l);
            dr = soft_clip(lp_r);
        end
        xl = in_l;
        xr = reg_mono ? xl : longint'(in_r);
        sum2 = (xl + xr) * 32768;
        if (mono_path) begin
            wl = dl;
            wr = dl;
            gain = 65536;
            fl = clip(rnd16(sum2 + dl * fbk));
            if (reg_tape) fl = soft_clip(fl);
            fr = fl;
        end else begin
            wl = -dr;
            wr = dl;
            gain = 46334;
            fl = clip(rnd16(sum2 + dr * fbk));
            fr = clip(rnd16(sum2 + dl * fbk));
            if (reg_tape) begin
                fl = soft_clip(fl);
                fr = soft_clip(fr);
            end
        end
        echo_l[wr_ptr] = int'(fl);
        echo_r[wr_ptr] = int'(fr);
        res.l = 16'(clip((xl * (65536 - mix) * 65536 + wl * mix * gain + 64'sd2147483648) >>> 32));
        res.r = 16'(clip((xr * (65536 - mix) * 65536 + wr * mix * gain + 64'sd2147483648) >>> 32));
        wr_ptr = (wr_ptr + 1) % DEPTH;
        return res;
    endfunction

    // Wait until every output pair is in, then let the pipe settle
    task automatic drain;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_DELAY_LENGTH: reg_delay  = value & 17'h1FFFF;
            CFG_MIX_LEVEL:    reg_mix    = value & 17'h1FFFF;
            CFG_FEEDBACK:     reg_fbk    = value & 16'hFFFF;
            CFG_TAPE_MODE:    reg_tape   = value[0];
            CFG_MONO_INPUT:   reg_mono   = value[0];
            CFG_CENTRE_MODE:  reg_centre = value[0];
            default: ;
        endcase
    endtask

    task automatic write_all(int unsigned dly, int unsigned mx, int unsigned fb,
                             bit tp, bit mo, bit ce);
        drain();
        write_reg(CFG_DELAY_LENGTH, dly);
        write_reg(CFG_MIX_LEVEL, mx);
        write_reg(CFG_FEEDBACK, fb);
        write_reg(CFG_TAPE_MODE, tp);
        write_reg(CFG_MONO_INPUT, mo);
        write_reg(CFG_CENTRE_MODE, ce);
    endtask

    // Send one pair; queue the typed or modeled output pair on acceptance
    task automatic send_pair(t_row row);
        t_pair p;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.r, row.l};
        do @(posedge i_clk); while (!s_axis_tready);
        p = delay_step(row.l, row.r);
        if (row.typed) begin
            p.l = row.el;
            p.r = row.er;
        end
        expected_pairs.push_back(p);
        if (reg_tape) tape_items++;
        if (reg_mono || reg_centre) mono_items++;
        else cross_items++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at output %0d: %s got %0d expected %0d",
                 outputs_seen, what, got, want);
    endtask

    // Output side: random stall bursts, compare against oldest expectation
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_pair want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = expected_pairs.pop_front();
                if ($signed(m_axis_tdata[15:0]) != want.l)
                    report_mismatch("out_left", $signed(m_axis_tdata[15:0]), want.l);
                if ($signed(m_axis_tdata[31:16]) != want.r)
                    report_mismatch("out_right", $signed(m_axis_tdata[31:16]), want.r);
            end
            outputs_seen++;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_MAX) begin
            $display("FAIL stereo_ping_pong_tape_delay");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_sample;
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed rows: under reset settings the typed rows give dry/2 with silent taps
    t_row directed [NUM_DIRECTED] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'sd0,      16'sd0},
        '{16'sh7FFF,   16'sh8000,   1'b1, 16'sd16384,  -16'sd16384},
        '{16'sh8000,   16'sh7FFF,   1'b1, -16'sd16384, 16'sd16384},
        '{-16'sd1,     16'sd1,      1'b1, 16'sd0,      16'sd1},
        '{16'sh5555,   16'shAAAA,   1'b0, 16'sd0,      16'sd0},
        '{16'sh7FFF,   16'sh7FFF,   1'b0, 16'sd0,      16'sd0},
        '{16'sh8000,   16'sh8000,   1'b0, 16'sd0,      16'sd0},
        '{16'sd1234,   -16'sd4321,  1'b0, 16'sd0,      16'sd0},
        '{16'sh7FFF,   16'sh8000,   1'b0, 16'sd0,      16'sd0},
        '{16'sh0F0F,   16'shF0F0,   1'b0, 16'sd0,      16'sd0},
        '{16'sh7FFF,   16'sh7FFF,   1'b0, 16'sd0,      16'sd0},
        '{16'sh8000,   16'sh7FFF,   1'b0, 16'sd0,      16'sd0}
    };

    initial begin
        t_row        row;
        int unsigned dly, mx, fb;
        build_tanh();
        for (int i = 0; i < DEPTH; i++) begin
            echo_l[i] = 0;
            echo_r[i] = 0;
        end
        wr_ptr = 0;
        lp_l = 0;
        lp_r = 0;
        reg_delay = RST_DELAY_LENGTH;
        reg_mix = RST_MIX_LEVEL;
        reg_fbk = RST_FEEDBACK;
        reg_tape = 1'b0;
        reg_mono = 1'b0;
        reg_centre = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then short delay with feedback overflow
        // and tape saturation, then centre and mono paths
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            // drop valid so the last pair is not taken again while draining
            if (i == 4 || i == 8 || i == 10) s_axis_tvalid <= 1'b0;
            if (i == 4) write_all(1, 131071, 65535, 1, 0, 0);
            if (i == 8) write_all(0, 0, 64881, 1, 0, 1);
            if (i == 10) write_all(2, 65536, 0, 0, 1, 0);
            send_pair(directed[i]);
        end
        s_axis_tvalid <= 1'b0;

        // Random phases, each with its own setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0: dly = 0;
                1: dly = 131071;
                2: dly = $urandom_range(0, 131071);
                default: dly = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 5))
                0: mx = 0;
                1: mx = 65536;
                2: mx = $urandom_range(65537, 131071);
                default: mx = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 5))
                0: fb = 0;
                1: fb = 64881;
                2: fb = $urandom_range(64882, 65535);
                default: fb = $urandom_range(0, 65535);
            endcase
            if (ph == NUM_PHASES - 1) idle_on = 1'b0;
            write_all(dly, mx, fb, $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_LEN; k++) begin
                // hold off once mid-phase until the output side is empty
                if (ph == 2 && k == PHASE_LEN / 2) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (expected_pairs.size() != 0) @(posedge i_clk);
                end
                row.l = rand_sample();
                row.r = rand_sample();
                row.typed = 1'b0;
                row.el = '0;
                row.er = '0;
                send_pair(row);
            end
            s_axis_tvalid <= 1'b0;
        end

        drain();
        $display("covered %0d output pairs: %0d cross-feed, %0d mono/centre, %0d tape",
                 outputs_seen, cross_items, mono_items, tape_items);
        if (errors == 0) begin
            $display("PASS stereo_ping_pong_tape_delay");
        end else begin
            $display("FAIL stereo_ping_pong_tape_delay");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/spptd_pkg.sv
rtl/spptd_tanh_rom.sv
rtl/spptd_ctrl.sv
rtl/spptd_dpath.sv
rtl/stereo_ping_pong_tape_delay.sv
tb/stereo_ping_pong_tape_delay_test.sv
